/* rtl/core/bpp_pkg.sv */
// Shared types, constants and Q8.24 arithmetic helpers for the Boris particle push core.
`timescale 1ns / 1ps
package bpp_pkg;

	typedef logic signed [31:0] q_t;
	typedef q_t [2:0] vec_t;
	typedef logic signed [39:0] prod_t;
	typedef logic signed [41:0] wide_t;

	typedef enum logic [2:0] {
		REG_HKS = 3'd0,
		REG_CX  = 3'd1,
		REG_CY  = 3'd2,
		REG_CZ  = 3'd3
	} cfg_idx_t;

	localparam q_t QONE    = 32'sd16777216;
	localparam q_t Q_THIRD = 32'sd5592405;
	localparam q_t Q_2_15  = 32'sd2236962;

	// Quotient bits resolved per divider stage, and the stage count for 32 bits.
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = 32 / DIV_BITS;
	localparam int DIV_LAT   = DIV_STEPS + 1;

	typedef struct packed {
		logic        neg;
		logic [31:0] rem;
		logic [31:0] lo;
		logic [31:0] quo;
		logic [30:0] den;
	} div_t;

	typedef struct packed {
		vec_t u;
		vec_t ha;
		vec_t pos;
		vec_t c2;
	} side_t;

	function automatic q_t sat(input wide_t x);
		if (x > 42'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -42'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// Exact product rounded half up to Q8.24, not saturated.
	function automatic prod_t rmul(input q_t a, input q_t b);
		logic signed [63:0] ae;
		logic signed [63:0] be;
		logic signed [63:0] p;
		ae = a;
		be = b;
		p = ae * be + 64'sd8388608;
		return p[63:24];
	endfunction

	function automatic q_t qmul(input q_t a, input q_t b);
		wide_t w;
		w = rmul(a, b);
		return sat(w);
	endfunction

	function automatic q_t add_sat(input q_t a, input q_t b);
		wide_t x;
		wide_t y;
		x = a;
		y = b;
		return sat(x + y);
	endfunction

	function automatic q_t cross1(input q_t a, input q_t b, input q_t c, input q_t d);
		wide_t x;
		wide_t y;
		x = rmul(a, b);
		y = rmul(c, d);
		return sat(x - y);
	endfunction

	function automatic vec_t cross3(input vec_t a, input vec_t b);
		vec_t r;
		r[0] = cross1(a[1], b[2], a[2], b[1]);
		r[1] = cross1(a[2], b[0], a[0], b[2]);
		r[2] = cross1(a[0], b[1], a[1], b[0]);
		return r;
	endfunction

	function automatic q_t sat3(input prod_t a, input prod_t b, input prod_t c);
		wide_t x;
		wide_t y;
		wide_t z;
		x = a;
		y = b;
		z = c;
		return sat(x + y + z);
	endfunction

endpackage

/* rtl/core/boris_particle_push_core.sv */
// Top level of the Boris particle push core: kick, rotation, divider and position update.
// Throughput: one particle per cycle while the result is not stalled; the 9-stage divider is fully pipelined.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers to zero.
// Configuration writes are always ready and take effect on the next cycle.
`timescale 1ns / 1ps
module boris_particle_push_core (
	input  logic               clk,
	input  logic               arst_n,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] mom_x,
	input  logic signed [31:0] mom_y,
	input  logic signed [31:0] mom_z,
	input  logic signed [31:0] efield_x,
	input  logic signed [31:0] efield_y,
	input  logic signed [31:0] efield_z,
	input  logic signed [31:0] bfield_x,
	input  logic signed [31:0] bfield_y,
	input  logic signed [31:0] bfield_z,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_mom_x,
	output logic signed [31:0] new_mom_y,
	output logic signed [31:0] new_mom_z
);
	import bpp_pkg::*;

	// Configuration registers. The Courant factors are unsigned and 31 bits wide.
	q_t          hks_q;
	logic [30:0] courant_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hks_q <= '0;
			for (int i = 0; i < 3; i++) begin
				courant_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HKS: hks_q        <= cfg_data;
				REG_CX:  courant_q[0] <= cfg_data[30:0];
				REG_CY:  courant_q[1] <= cfg_data[30:0];
				REG_CZ:  courant_q[2] <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a finished result is being held back.
	logic en;
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	vec_t pos_in, mom_in, e_in, b_in;
	assign pos_in = {pos_z, pos_y, pos_x};
	assign mom_in = {mom_z, mom_y, mom_x};
	assign e_in   = {efield_z, efield_y, efield_x};
	assign b_in   = {bfield_z, bfield_y, bfield_x};

	// Stage registers. Each stage has at most one rank of multipliers in front of it.
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic  v_s18, v_s19, v_s20, v_s21;
	vec_t  ha_s1, mom_s1, pos_s1, b_s1;
	prod_t sq_s1 [3];
	q_t    hh_s1;
	vec_t  u_s2, ha_s2, pos_s2, b_s2;
	q_t    hh_s2, b2_s2;
	vec_t  u_s3, ha_s3, pos_s3, b_s3, c1_s3;
	q_t    s_s3, b2_s3;
	vec_t  u_s4, ha_s4, pos_s4, b_s4, c1_s4;
	q_t    s_s4, b2_s4, t1_s4;
	vec_t  u_s5, ha_s5, pos_s5, b_s5, c1_s5;
	q_t    b2_s5, t2_s5;
	vec_t  u_s6, ha_s6, pos_s6, b_s6, c1_s6;
	q_t    b2_s6, t_s6;
	vec_t  u_s7, ha_s7, pos_s7, b_s7, p_s7;
	q_t    b2_s7, t_s7, tt_s7;
	vec_t  u_s8, ha_s8, pos_s8, c2_s8;
	q_t    t_s8, den_s8;
	side_t side_s8, side_d;
	logic  div_v, div_neg;
	logic [31:0] div_quo;
	vec_t  u_s18, ha_s18, pos_s18, c2_s18;
	q_t    r_s18;
	vec_t  u_s19, ha_s19, pos_s19;
	vec_t  u_s20, pos_s20;
	vec_t  pos_s21, mom_s21;

	// Rotation factor after the divider: r = 2 * sat(t / den), sign restored.
	q_t r_next;
	always_comb begin
		wide_t qs;
		q_t    r1;
		qs = {10'd0, div_quo};
		if (div_neg) begin
			qs = -qs;
		end
		r1 = sat(qs);
		r_next = add_sat(r1, r1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
		end else if (en) begin
			v_s1  <= item_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s18 <= div_v;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
			v_s21 <= v_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Half electric kick, h squared and the squared field components.
			for (int i = 0; i < 3; i++) begin
				ha_s1[i] <= qmul(hks_q, e_in[i]);
				sq_s1[i] <= rmul(b_in[i], b_in[i]);
			end
			hh_s1  <= qmul(hks_q, hks_q);
			mom_s1 <= mom_in;
			pos_s1 <= pos_in;
			b_s1   <= b_in;

			// First half kick applied and |B|^2 summed.
			for (int i = 0; i < 3; i++) begin
				u_s2[i] <= add_sat(mom_s1[i], ha_s1[i]);
			end
			b2_s2  <= sat3(sq_s1[0], sq_s1[1], sq_s1[2]);
			hh_s2  <= hh_s1;
			ha_s2  <= ha_s1;
			pos_s2 <= pos_s1;
			b_s2   <= b_s1;

			// Series argument s and the first cross product u x B.
			s_s3   <= qmul(hh_s2, b2_s2);
			c1_s3  <= cross3(u_s2, b_s2);
			b2_s3  <= b2_s2;
			u_s3   <= u_s2;
			ha_s3  <= ha_s2;
			pos_s3 <= pos_s2;
			b_s3   <= b_s2;

			// Tangent series: 1/3 + s*2/15.
			t1_s4  <= add_sat(Q_THIRD, qmul(s_s3, Q_2_15));
			s_s4   <= s_s3;
			c1_s4  <= c1_s3;
			b2_s4  <= b2_s3;
			u_s4   <= u_s3;
			ha_s4  <= ha_s3;
			pos_s4 <= pos_s3;
			b_s4   <= b_s3;

			// 1 + s*(1/3 + s*2/15).
			t2_s5  <= add_sat(QONE, qmul(s_s4, t1_s4));
			c1_s5  <= c1_s4;
			b2_s5  <= b2_s4;
			u_s5   <= u_s4;
			ha_s5  <= ha_s4;
			pos_s5 <= pos_s4;
			b_s5   <= b_s4;

			// Corrected tangent factor t.
			t_s6   <= qmul(hks_q, t2_s5);
			c1_s6  <= c1_s5;
			b2_s6  <= b2_s5;
			u_s6   <= u_s5;
			ha_s6  <= ha_s5;
			pos_s6 <= pos_s5;
			b_s6   <= b_s5;

			// Intermediate vector u' and t squared.
			tt_s7 <= qmul(t_s6, t_s6);
			for (int i = 0; i < 3; i++) begin
				p_s7[i] <= add_sat(u_s6[i], qmul(t_s6, c1_s6[i]));
			end
			t_s7   <= t_s6;
			b2_s7  <= b2_s6;
			u_s7   <= u_s6;
			ha_s7  <= ha_s6;
			pos_s7 <= pos_s6;
			b_s7   <= b_s6;

			// Divisor 1 + b2*t^2 (never below one) and the second cross product.
			den_s8 <= add_sat(QONE, qmul(b2_s7, tt_s7));
			c2_s8  <= cross3(p_s7, b_s7);
			t_s8   <= t_s7;
			u_s8   <= u_s7;
			ha_s8  <= ha_s7;
			pos_s8 <= pos_s7;

			// Divider output: rotation factor r.
			r_s18   <= r_next;
			u_s18   <= side_d.u;
			ha_s18  <= side_d.ha;
			pos_s18 <= side_d.pos;
			c2_s18  <= side_d.c2;

			// Rotation applied.
			for (int i = 0; i < 3; i++) begin
				u_s19[i] <= add_sat(u_s18[i], qmul(r_s18, c2_s18[i]));
			end
			ha_s19  <= ha_s18;
			pos_s19 <= pos_s18;

			// Second half kick.
			for (int i = 0; i < 3; i++) begin
				u_s20[i] <= add_sat(u_s19[i], ha_s19[i]);
			end
			pos_s20 <= pos_s19;

			// Position update and output register.
			for (int i = 0; i < 3; i++) begin
				pos_s21[i] <= add_sat(pos_s20[i], qmul(u_s20[i], {1'b0, courant_q[i]}));
			end
			mom_s21 <= u_s20;
		end
	end

	assign side_s8 = '{u: u_s8, ha: ha_s8, pos: pos_s8, c2: c2_s8};

	bpp_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.v_in  (v_s8),
		.num   (t_s8),
		.den   (den_s8[30:0]),
		.v_out (div_v),
		.neg   (div_neg),
		.quo   (div_quo)
	);

	bpp_delay #(
		.W($bits(side_t)),
		.D(DIV_LAT)
	) u_side (
		.clk(clk),
		.en (en),
		.d  (side_s8),
		.q  (side_d)
	);

	assign result_valid = v_s21;
	assign new_pos_x    = pos_s21[0];
	assign new_pos_y    = pos_s21[1];
	assign new_pos_z    = pos_s21[2];
	assign new_mom_x    = mom_s21[0];
	assign new_mom_y    = mom_s21[1];
	assign new_mom_z    = mom_s21[2];

	// An accepted transaction always lands in the first stage.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> v_s1)
		else $error("accepted transaction did not enter stage one");

	// The divider output hands its valid bit to the rotation stage when advancing.
	a_div_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> v_s18 == $past(div_v))
		else $error("valid bit lost between divider and rotation stage");

	// The squared field magnitude is never negative.
	a_b2_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !b2_s2[31])
		else $error("negative field magnitude");

	// The divisor is at least one, so the divider never sees zero.
	a_den_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> den_s8 >= QONE)
		else $error("divisor below one");
endmodule

/* rtl/core/bpp_delay.sv */
// Enabled shift line that carries side data alongside the divider.
`timescale 1ns / 1ps
module bpp_delay #(
	parameter int W = 8,
	parameter int D = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] sh_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

	assign q = sh_q[D-1];
endmodule

/* rtl/core/bpp_div_step.sv */
// One registered stage of the restoring divider, DIV_BITS quotient bits per stage.
`timescale 1ns / 1ps
module bpp_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  bpp_pkg::div_t d_in,
	output logic          v_out,
	output bpp_pkg::div_t d_out
);
	import bpp_pkg::*;

	div_t nx;

	always_comb begin
		logic [32:0] r;
		nx = d_in;
		for (int k = 0; k < DIV_BITS; k++) begin
			r = {nx.rem, nx.lo[31]};
			nx.lo = {nx.lo[30:0], 1'b0};
			if (r >= {2'b00, nx.den}) begin
				r = r - {2'b00, nx.den};
				nx.quo = {nx.quo[30:0], 1'b1};
			end else begin
				nx.quo = {nx.quo[30:0], 1'b0};
			end
			nx.rem = r[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nx;
		end
	end
endmodule

/* rtl/core/bpp_divider.sv */
// Pipelined rounded Q8.24 divider: sign and numerator setup, then restoring stages.
`timescale 1ns / 1ps
module bpp_divider (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_in,
	input  bpp_pkg::q_t  num,
	input  logic [30:0]  den,
	output logic         v_out,
	output logic         neg,
	output logic [31:0]  quo
);
	import bpp_pkg::*;

	div_t st   [DIV_STEPS+1];
	logic vst  [DIV_STEPS+1];
	div_t prep;

	// Magnitude times one, plus half the divisor, gives round-half-away after truncation.
	always_comb begin
		logic [31:0] mag;
		logic [55:0] n;
		mag = num[31] ? (32'd0 - num) : num;
		n = {mag, 24'd0} + {26'd0, den[30:1]};
		prep.neg = num[31];
		prep.rem = {8'd0, n[55:32]};
		prep.lo  = n[31:0];
		prep.quo = 32'd0;
		prep.den = den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vst[0] <= 1'b0;
		end else if (en) begin
			vst[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= prep;
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		bpp_div_step u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (vst[g]),
			.d_in  (st[g]),
			.v_out (vst[g+1]),
			.d_out (st[g+1])
		);
	end

	assign v_out = vst[DIV_STEPS];
	assign neg   = st[DIV_STEPS].neg;
	assign quo   = st[DIV_STEPS].quo;
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Boris particle push core.
`timescale 1ns / 1ps
module testbench;
	import bpp_pkg::*;

	// Generous run limit: about 1450 particles with heavy idling and stalling,
	// a long receiver hold-off, and drain pauses between configuration phases.
	localparam int CYCLE_LIMIT = 400000;
	// Pipeline depth from the head of the core, with some margin.
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 180;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	// One particle: position, momentum, E field, B field, three axes each.
	typedef struct {
		q_t f[12];
	} ptcl_rec_t;

	// One pushed result: new position then new momentum.
	typedef struct {
		q_t v[6];
	} pushed_t;

	// A particle waiting to be accepted, with an optional hand-typed answer.
	typedef struct {
		bit      typed;
		pushed_t answer;
	} pending_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        item_valid;
	logic        item_stall;
	q_t          pos_x, pos_y, pos_z;
	q_t          mom_x, mom_y, mom_z;
	q_t          efield_x, efield_y, efield_z;
	q_t          bfield_x, bfield_y, bfield_z;
	logic        result_valid;
	logic        result_stall;
	q_t          new_pos_x, new_pos_y, new_pos_z;
	q_t          new_mom_x, new_mom_y, new_mom_z;

	boris_particle_push_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.mom_x       (mom_x),
		.mom_y       (mom_y),
		.mom_z       (mom_z),
		.efield_x    (efield_x),
		.efield_y    (efield_y),
		.efield_z    (efield_z),
		.bfield_x    (bfield_x),
		.bfield_y    (bfield_y),
		.bfield_z    (bfield_z),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.new_pos_x   (new_pos_x),
		.new_pos_y   (new_pos_y),
		.new_pos_z   (new_pos_z),
		.new_mom_x   (new_mom_x),
		.new_mom_y   (new_mom_y),
		.new_mom_z   (new_mom_z)
	);

	// Our own copy of the configuration registers.
	longint kick_h;
	longint courant[3];

	// Answers for accepted particles, oldest first, and particles in flight
	// on the input channel that have not been accepted yet.
	pushed_t  expected_q[$];
	pending_t offered_q[$];

	int  mismatches;
	int  cycles;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_left;
	ptcl_rec_t dir_rows[$];
	bit        dir_typed[$];

	// ---------------------------------------------------------------------
	// Fixed-point predictor of one Boris push.
	// ---------------------------------------------------------------------
	function automatic longint clamp(input longint x);
		if (x > Q_MAX) begin
			return Q_MAX;
		end
		if (x < Q_MIN) begin
			return Q_MIN;
		end
		return x;
	endfunction

	// Exact product rounded half up to Q8.24; the arithmetic shift floors.
	function automatic longint round_prod(input longint a, input longint b);
		return (a * b + 64'sd8388608) >>> 24;
	endfunction

	function automatic longint sat_prod(input longint a, input longint b);
		return clamp(round_prod(a, b));
	endfunction

	function automatic longint cross_term(input longint a, input longint b,
			input longint c, input longint d);
		return clamp(round_prod(a, b) - round_prod(c, d));
	endfunction

	// Quotient rounded to nearest with halves away from zero; den >= 1.0.
	function automatic longint round_quot(input longint n, input longint den);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag * longint'(QONE) + den / 2) / den;
		return clamp((n < 0) ? -q : q);
	endfunction

	function automatic pushed_t push_particle(input ptcl_rec_t p);
		longint  h, bx, by, bz, hax, hay, haz, ux, uy, uz;
		longint  b2, s, t, den, r, px, py, pz;
		pushed_t o;
		h = kick_h;
		bx = p.f[9];
		by = p.f[10];
		bz = p.f[11];
		hax = sat_prod(h, p.f[6]);
		hay = sat_prod(h, p.f[7]);
		haz = sat_prod(h, p.f[8]);
		ux = clamp(p.f[3] + hax);
		uy = clamp(p.f[4] + hay);
		uz = clamp(p.f[5] + haz);
		b2 = clamp(round_prod(bx, bx) + round_prod(by, by) + round_prod(bz, bz));
		s = sat_prod(sat_prod(h, h), b2);
		// Tangent factor with its series correction.
		t = sat_prod(s, Q_2_15);
		t = clamp(longint'(Q_THIRD) + t);
		t = sat_prod(s, t);
		t = clamp(longint'(QONE) + t);
		t = sat_prod(h, t);
		den = clamp(longint'(QONE) + sat_prod(b2, sat_prod(t, t)));
		r = round_quot(t, den);
		r = clamp(r + r);
		px = clamp(ux + sat_prod(t, cross_term(uy, bz, uz, by)));
		py = clamp(uy + sat_prod(t, cross_term(uz, bx, ux, bz)));
		pz = clamp(uz + sat_prod(t, cross_term(ux, by, uy, bx)));
		ux = clamp(ux + sat_prod(r, cross_term(py, bz, pz, by)));
		uy = clamp(uy + sat_prod(r, cross_term(pz, bx, px, bz)));
		uz = clamp(uz + sat_prod(r, cross_term(px, by, py, bx)));
		ux = clamp(ux + hax);
		uy = clamp(uy + hay);
		uz = clamp(uz + haz);
		o.v[0] = q_t'(clamp(p.f[0] + sat_prod(ux, courant[0])));
		o.v[1] = q_t'(clamp(p.f[1] + sat_prod(uy, courant[1])));
		o.v[2] = q_t'(clamp(p.f[2] + sat_prod(uz, courant[2])));
		o.v[3] = q_t'(ux);
		o.v[4] = q_t'(uy);
		o.v[5] = q_t'(uz);
		return o;
	endfunction

	// ---------------------------------------------------------------------
	// Clock, reset and run limit.
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// The cycle counter is the only timeout; it ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Result side: random stall, plus a long hold-off counted down here.
	// While it lasts the sender keeps offering, so the pipeline fills and
	// the core has to stall its input channel.
	// ---------------------------------------------------------------------
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				result_stall = 1'b1;
			end else begin
				result_stall = ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge. A particle accepted
	// on the input side gets its answer queued; a result transaction is
	// compared against the oldest queued answer.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		ptcl_rec_t p;
		pushed_t   got;
		pushed_t   want;
		pending_t  pend;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				p.f = '{pos_x, pos_y, pos_z, mom_x, mom_y, mom_z,
					efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z};
				pend = offered_q.pop_front();
				expected_q.push_back(pend.typed ? pend.answer : push_particle(p));
			end
			if (result_valid && !result_stall) begin
				got.v = '{new_pos_x, new_pos_y, new_pos_z,
					new_mom_x, new_mom_y, new_mom_z};
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result transaction at cycle %0d", cycles);
					end
				end else begin
					want = expected_q.pop_front();
					for (int i = 0; i < 6; i++) begin
						if (got.v[i] !== want.v[i]) begin
							mismatches++;
							if (mismatches <= 10) begin
								$display("field %0d mismatch at cycle %0d: expected %h, got %h",
									i, cycles, want.v[i], got.v[i]);
							end
						end
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers.
	// ---------------------------------------------------------------------

	// Offer one particle and hold it until the core takes it. Valid stays
	// high across back-to-back transactions.
	task automatic offer(input ptcl_rec_t p, input bit typed);
		pending_t pend;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		{pos_x, pos_y, pos_z} = {p.f[0], p.f[1], p.f[2]};
		{mom_x, mom_y, mom_z} = {p.f[3], p.f[4], p.f[5]};
		{efield_x, efield_y, efield_z} = {p.f[6], p.f[7], p.f[8]};
		{bfield_x, bfield_y, bfield_z} = {p.f[9], p.f[10], p.f[11]};
		pend.typed = typed;
		// With all registers at zero the push leaves the particle unchanged.
		for (int i = 0; i < 6; i++) begin
			pend.answer.v[i] = p.f[i];
		end
		offered_q.push_back(pend);
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	// Registers change only with the pipeline empty and drained.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		item_valid = 1'b0;
		while (expected_q.size() != 0 || offered_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HKS: begin
				kick_h = longint'($signed(data));
			end
			REG_CX: begin
				courant[0] = longint'(data[30:0]);
			end
			REG_CY: begin
				courant[1] = longint'(data[30:0]);
			end
			REG_CZ: begin
				courant[2] = longint'(data[30:0]);
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(input logic [31:0] h, input logic [31:0] cx,
			input logic [31:0] cy, input logic [31:0] cz);
		write_reg(REG_HKS, h);
		write_reg(REG_CX, cx);
		write_reg(REG_CY, cy);
		write_reg(REG_CZ, cz);
	endtask

	// Field values: full-range noise, physically sized values, or extremes.
	function automatic q_t pick_value(input int small_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < small_pct) begin
			return q_t'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
		end
		if (roll < small_pct + 8) begin
			case ($urandom_range(4))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh00000000;
				3: return 32'shffffffff;
				default: return QONE;
			endcase
		end
		return q_t'($urandom);
	endfunction

	function automatic ptcl_rec_t random_particle();
		ptcl_rec_t p;
		for (int i = 0; i < 12; i++) begin
			// Fields mostly within a few units, so the rotation is exercised
			// without saturating everything; the rest is extremes or full-range noise.
			p.f[i] = pick_value(70);
		end
		return p;
	endfunction

	function automatic ptcl_rec_t uniform_particle(input q_t pv, input q_t mv,
			input q_t ev, input q_t bv);
		ptcl_rec_t p;
		for (int i = 0; i < 3; i++) begin
			p.f[i] = pv;
			p.f[i + 3] = mv;
			p.f[i + 6] = ev;
			p.f[i + 9] = bv;
		end
		return p;
	endfunction

	// ---------------------------------------------------------------------
	// Main sequence.
	// ---------------------------------------------------------------------
	initial begin
		ptcl_rec_t p;
		mismatches = 0;
		cycles = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		kick_h = 0;
		courant = '{0, 0, 0};
		cfg_valid = 1'b0;
		cfg_index = REG_HKS;
		cfg_data = '0;
		item_valid = 1'b0;
		{pos_x, pos_y, pos_z, mom_x, mom_y, mom_z} = '0;
		{efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z} = '0;
		@(posedge arst_n);
		@(negedge clk);

		// Directed table. The first rows run with the reset configuration,
		// where the push is an identity, so their answers are typed in.
		dir_rows.push_back(uniform_particle(32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff));
		dir_typed.push_back(1'b1);
		dir_rows.push_back(uniform_particle(32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000));
		dir_typed.push_back(1'b1);
		dir_rows.push_back(uniform_particle(0, 0, 0, 0));
		dir_typed.push_back(1'b1);
		dir_rows.push_back(uniform_particle(32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000));
		dir_typed.push_back(1'b1);
		dir_rows.push_back(uniform_particle(-1, 1, -1, 1));
		dir_typed.push_back(1'b1);
		for (int i = 0; i < dir_rows.size(); i++) begin
			offer(dir_rows[i], dir_typed[i]);
		end

		// A small positive kick scale and Courant factors of one half, one and one quarter.
		write_all(32'd167772, 32'h0080_0000, 32'h0100_0000, 32'h0040_0000);
		offer(uniform_particle(QONE, QONE, QONE, 0), 1'b0);          // no magnetic field
		offer(uniform_particle(QONE, QONE, 0, QONE), 1'b0);          // pure rotation
		offer(uniform_particle(0, QONE, 32'sh7fffffff, QONE), 1'b0); // largest electric field
		offer(uniform_particle(0, QONE, QONE, 32'sh7fffffff), 1'b0); // |B|^2 saturates
		offer(uniform_particle(32'sh7fffffff, 32'sh7fffffff, QONE, QONE), 1'b0);
		offer(uniform_particle(32'sh80000000, 32'sh80000000, QONE, QONE), 1'b0);

		// Negative extreme kick scale with the largest Courant factors.
		write_all(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
		offer(uniform_particle(0, QONE, QONE, QONE), 1'b0);
		offer(uniform_particle(QONE, -QONE, QONE, -QONE), 1'b0);
		offer(uniform_particle(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000), 1'b0);

		// Positive extreme kick scale, which pushes the tangent series and
		// the divider denominator to saturation.
		write_all(32'h7fff_ffff, 0, 32'h0000_0001, 32'h0100_0000);
		offer(uniform_particle(QONE, QONE, QONE, QONE), 1'b0);
		offer(uniform_particle(QONE, QONE, -QONE, 32'sh00010000), 1'b0);
		offer(uniform_particle(0, 32'sh80000000, 32'sh7fffffff, 0), 1'b0);

		// Random phases, each with its own idling pattern and configuration.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			// An out-of-range index must leave every register alone.
			write_reg(3'(4 + $urandom_range(3)), $urandom);
			case (ph)
				1: write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
				5: write_all(32'h8000_0000, 0, 0, 0);
				default: write_all(
					($urandom_range(3) == 0) ? $urandom
						: 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000),
					$urandom_range(32'h0200_0000), $urandom_range(32'h0200_0000),
					$urandom);
			endcase
			if (ph == 0) begin
				// Long hold-off on the result side with the sender at full rate.
				hold_left = 400;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				p = random_particle();
				offer(p, 1'b0);
			end
		end
		item_valid = 1'b0;

		// Drain, then give the core time to show any stray result.
		while (expected_q.size() != 0 || offered_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
